/* design/tcw_pkg.sv */
`default_nettype none

package tcw_pkg;

  localparam int MAX_CELLS = 8192;
  localparam int CELL_AW   = $clog2(MAX_CELLS);
  localparam int CODE_W    = 16;
  localparam int ATTR_W    = 8;
  localparam int CELL_W    = CODE_W + ATTR_W;
  localparam int COLS_W    = 8;
  localparam int ROWS_W    = 7;
  localparam int DIV_W     = CELL_AW + 1;
  localparam int DIV_CW    = $clog2(DIV_W);
  localparam int CFG_IW    = 1;

  localparam logic [2:0] CMD_WRITE  = 3'd0;
  localparam logic [2:0] CMD_GOTO   = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_COLOUR = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  localparam logic [CODE_W-1:0] CH_BS    = 16'd8;
  localparam logic [CODE_W-1:0] CH_LF    = 16'd10;
  localparam logic [CODE_W-1:0] CH_CR    = 16'd13;
  localparam logic [CODE_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [CODE_W-1:0] CH_NULL  = 16'd0;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  localparam logic [CFG_IW-1:0] REG_COLUMNS = 1'b0;
  localparam logic [CFG_IW-1:0] REG_ROWS    = 1'b1;

  localparam logic [COLS_W-1:0] COLUMNS_RESET = 8'd80;
  localparam logic [ROWS_W-1:0] ROWS_RESET    = 7'd25;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_MUL,
    ST_READ,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

/* design/tcw_divmod.sv */
`default_nettype none

module tcw_divmod (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tcw_pkg::div_req_t req,
  output tcw_pkg::div_rsp_t      rsp
);

  logic                           busy;
  logic                           done;
  logic [tcw_pkg::DIV_CW-1:0]     cnt;
  logic [tcw_pkg::DIV_W-1:0]      rem;
  logic [tcw_pkg::DIV_W-1:0]      quo;
  logic [tcw_pkg::DIV_W-1:0]      dvs;

  logic                           fast;
  logic                           ge0;
  logic [tcw_pkg::DIV_W:0]        rem_sh;
  logic                           ge;
  logic [tcw_pkg::DIV_W:0]        rem_sub;

  assign fast    = {1'b0, req.dividend} < {req.divisor, 1'b0};
  assign ge0     = req.dividend >= req.divisor;
  assign rem_sh  = {rem, quo[tcw_pkg::DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= '0;
        if (fast) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == tcw_pkg::DIV_CW'(tcw_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs <= req.divisor;
      if (fast) begin
        quo <= {{(tcw_pkg::DIV_W-1){1'b0}}, ge0};
        rem <= ge0 ? req.dividend - req.divisor : req.dividend;
      end else begin
        quo <= req.dividend;
        rem <= '0;
      end
    end else if (busy) begin
      quo <= {quo[tcw_pkg::DIV_W-2:0], ge};
      rem <= ge ? rem_sub[tcw_pkg::DIV_W-1:0] : rem_sh[tcw_pkg::DIV_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire

/* design/text_console_char_writer_top.sv */
// Channel  Handshake            Payload
// -------  -------------------  ---------------------------------------------------
// in       in_valid / in_stall  command, char_code, pos_x, pos_y, text_color, back_color
// out      out_valid/ out_stall cursor_index, cell_char, cell_attr, current_attr
// cfg      cfg_write            cfg_index, cfg_data
//
// One item at a time: colour, spare commands and backspace from cell 0 skip the
// divider; a wrap settled by one subtract takes its fast path, others a full
// 14-step divider pass; read adds a cell store read; return and newline run two
// passes. Clear sweeps the active cells, one cell store write a cycle.
// After reset the cell store is swept over every cell with in_stall high.
// A finished result waits in the output register while out_stall is high.
`default_nettype none

module text_console_char_writer_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [2:0]                     command,
  input  wire logic [tcw_pkg::CODE_W-1:0]     char_code,
  input  wire logic [6:0]                     pos_x,
  input  wire logic [5:0]                     pos_y,
  input  wire logic [3:0]                     text_color,
  input  wire logic [3:0]                     back_color,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [tcw_pkg::CELL_AW-1:0]         cursor_index,
  output logic [tcw_pkg::CODE_W-1:0]          cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]          cell_attr,
  output logic [tcw_pkg::ATTR_W-1:0]          current_attr,
  input  wire logic                           cfg_write,
  input  wire logic [tcw_pkg::CFG_IW-1:0]     cfg_index,
  input  wire logic [tcw_pkg::COLS_W-1:0]     cfg_data
);

  tcw_pkg::state_t                state, state_next;

  logic [tcw_pkg::COLS_W-1:0]     columns;
  logic [tcw_pkg::ROWS_W-1:0]     rows;
  logic [tcw_pkg::COLS_W-1:0]     eff_cols;
  logic [tcw_pkg::ROWS_W-1:0]     eff_rows;
  logic [tcw_pkg::COLS_W+tcw_pkg::ROWS_W-1:0] area;
  logic [tcw_pkg::DIV_W-1:0]      total;

  logic [2:0]                     item_cmd;
  logic [tcw_pkg::CODE_W-1:0]     item_code;
  logic [6:0]                     item_x;
  logic [5:0]                     item_y;
  logic [3:0]                     item_fg;
  logic [3:0]                     item_bg;

  logic [tcw_pkg::CELL_AW-1:0]    cursor, cursor_next;
  logic [tcw_pkg::ATTR_W-1:0]     colour, colour_next;
  logic [tcw_pkg::CELL_AW-1:0]    clr_addr, clr_addr_next;
  logic [tcw_pkg::CELL_AW-1:0]    quot, quot_next;
  logic                           div_quo, div_quo_next;

  logic [tcw_pkg::DIV_W-1:0]      xy_prod;
  logic [tcw_pkg::DIV_W-1:0]      xy_sum;
  logic [tcw_pkg::DIV_W-1:0]      row_idx;
  logic [tcw_pkg::DIV_W+tcw_pkg::COLS_W-1:0] row_prod;
  logic [tcw_pkg::DIV_W-1:0]      total_m1;

  tcw_pkg::div_req_t              div_req;
  tcw_pkg::div_rsp_t              div_rsp;

  logic                           mem_we;
  logic                           mem_re;
  logic [tcw_pkg::CELL_AW-1:0]    mem_addr;
  logic [tcw_pkg::CELL_W-1:0]     mem_wdata;
  logic [tcw_pkg::CELL_W-1:0]     mem_rdata;
  logic [tcw_pkg::CELL_W-1:0]     mem [tcw_pkg::MAX_CELLS];

  logic                           accept;
  logic                           load_out;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != tcw_pkg::ST_IDLE);

  assign eff_cols = (columns == '0) ? tcw_pkg::COLS_W'(1) : columns;
  assign eff_rows = (rows == '0) ? tcw_pkg::ROWS_W'(1) : rows;
  assign area     = (tcw_pkg::COLS_W + tcw_pkg::ROWS_W)'(eff_cols) *
                    (tcw_pkg::COLS_W + tcw_pkg::ROWS_W)'(eff_rows);

  assign xy_prod  = tcw_pkg::DIV_W'(item_y) * tcw_pkg::DIV_W'(eff_cols);
  assign xy_sum   = xy_prod + {{(tcw_pkg::DIV_W-7){1'b0}}, item_x};
  assign row_idx  = {1'b0, quot} + {{(tcw_pkg::DIV_W-1){1'b0}}, (item_code == tcw_pkg::CH_LF)};
  assign row_prod = (tcw_pkg::DIV_W + tcw_pkg::COLS_W)'(row_idx) *
                    (tcw_pkg::DIV_W + tcw_pkg::COLS_W)'(eff_cols);
  assign total_m1 = total - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= tcw_pkg::COLUMNS_RESET;
      rows    <= tcw_pkg::ROWS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        tcw_pkg::REG_COLUMNS: columns <= cfg_data;
        tcw_pkg::REG_ROWS:    rows    <= cfg_data[tcw_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (area > (tcw_pkg::COLS_W + tcw_pkg::ROWS_W)'(tcw_pkg::MAX_CELLS)) begin
      total <= tcw_pkg::DIV_W'(tcw_pkg::MAX_CELLS);
    end else begin
      total <= area[tcw_pkg::DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd  <= command;
      item_code <= char_code;
      item_x    <= pos_x;
      item_y    <= pos_y;
      item_fg   <= text_color;
      item_bg   <= back_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tcw_pkg::ST_INIT;
      cursor   <= '0;
      colour   <= tcw_pkg::ATTR_RESET;
      clr_addr <= '0;
      div_quo  <= 1'b0;
    end else begin
      state    <= state_next;
      cursor   <= cursor_next;
      colour   <= colour_next;
      clr_addr <= clr_addr_next;
      div_quo  <= div_quo_next;
    end
  end

  always_ff @(posedge clk) begin
    quot <= quot_next;
  end

  always_comb begin
    state_next    = state;
    cursor_next   = cursor;
    colour_next   = colour;
    clr_addr_next = clr_addr;
    quot_next     = quot;
    div_quo_next  = div_quo;
    div_req       = '0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = clr_addr;
    mem_wdata     = {tcw_pkg::CH_NULL, tcw_pkg::ATTR_RESET};
    load_out      = 1'b0;
    case (state)
      tcw_pkg::ST_INIT: begin
        mem_we        = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == {tcw_pkg::CELL_AW{1'b1}}) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = tcw_pkg::ST_EXEC;
        end
      end
      tcw_pkg::ST_EXEC: begin
        case (item_cmd)
          tcw_pkg::CMD_WRITE: begin
            if (item_code == tcw_pkg::CH_BS) begin
              if (cursor == '0) begin
                cursor_next = total_m1[tcw_pkg::CELL_AW-1:0];
                state_next  = tcw_pkg::ST_DONE;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = {1'b0, cursor} - 1'b1;
                div_req.divisor  = total;
                div_quo_next     = 1'b0;
                state_next       = tcw_pkg::ST_DIV;
              end
            end else if (item_code inside {tcw_pkg::CH_CR, tcw_pkg::CH_LF}) begin
              div_req.start    = 1'b1;
              div_req.dividend = {1'b0, cursor};
              div_req.divisor  = {{(tcw_pkg::DIV_W-tcw_pkg::COLS_W){1'b0}}, eff_cols};
              div_quo_next     = 1'b1;
              state_next       = tcw_pkg::ST_DIV;
            end else begin
              mem_we           = 1'b1;
              mem_addr         = cursor;
              mem_wdata        = {item_code, colour};
              div_req.start    = 1'b1;
              div_req.dividend = {1'b0, cursor} + 1'b1;
              div_req.divisor  = total;
              div_quo_next     = 1'b0;
              state_next       = tcw_pkg::ST_DIV;
            end
          end
          tcw_pkg::CMD_GOTO, tcw_pkg::CMD_READ: begin
            div_req.start    = 1'b1;
            div_req.dividend = xy_sum;
            div_req.divisor  = total;
            div_quo_next     = 1'b0;
            state_next       = tcw_pkg::ST_DIV;
          end
          tcw_pkg::CMD_CLEAR: begin
            clr_addr_next = '0;
            state_next    = tcw_pkg::ST_CLEAR;
          end
          tcw_pkg::CMD_COLOUR: begin
            colour_next = {item_bg, item_fg};
            state_next  = tcw_pkg::ST_DONE;
          end
          default: begin
            state_next = tcw_pkg::ST_DONE;
          end
        endcase
      end
      tcw_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          if (div_quo) begin
            quot_next  = div_rsp.quo[tcw_pkg::CELL_AW-1:0];
            state_next = tcw_pkg::ST_MUL;
          end else if (item_cmd == tcw_pkg::CMD_READ) begin
            mem_re     = 1'b1;
            mem_addr   = div_rsp.rem[tcw_pkg::CELL_AW-1:0];
            state_next = tcw_pkg::ST_READ;
          end else begin
            cursor_next = div_rsp.rem[tcw_pkg::CELL_AW-1:0];
            state_next  = tcw_pkg::ST_DONE;
          end
        end
      end
      tcw_pkg::ST_MUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = row_prod[tcw_pkg::DIV_W-1:0];
        div_req.divisor  = total;
        div_quo_next     = 1'b0;
        state_next       = tcw_pkg::ST_DIV;
      end
      tcw_pkg::ST_READ: begin
        state_next = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_CLEAR: begin
        mem_we        = 1'b1;
        mem_wdata     = {tcw_pkg::CH_SPACE, colour};
        clr_addr_next = clr_addr + 1'b1;
        if ({1'b0, clr_addr} == total_m1) begin
          cursor_next   = '0;
          clr_addr_next = '0;
          state_next    = tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_addr];
    end
  end

  tcw_divmod u_divmod (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      cursor_index <= cursor;
      current_attr <= colour;
      if (item_cmd == tcw_pkg::CMD_READ) begin
        cell_char <= mem_rdata[tcw_pkg::CELL_W-1:tcw_pkg::ATTR_W];
        cell_attr <= mem_rdata[tcw_pkg::ATTR_W-1:0];
      end else begin
        cell_char <= '0;
        cell_attr <= '0;
      end
    end
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input taken while an item is in flight");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == tcw_pkg::ST_DIV)
    else $error("divider result with no consumer");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == tcw_pkg::ST_INIT || state == tcw_pkg::ST_EXEC ||
                state == tcw_pkg::ST_CLEAR))
    else $error("cell store write outside a writing state");

  a_clear_range: assert property (@(posedge clk) disable iff (rst)
    state == tcw_pkg::ST_CLEAR |-> ({1'b0, clr_addr} < total))
    else $error("clear sweep beyond active cells");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == tcw_pkg::ST_DONE))
    else $error("result raised outside completion");

endmodule

`default_nettype wire

/* verif/tb_text_console_char_writer_top.sv */
`default_nettype none

module tb_text_console_char_writer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam int GEOMETRIES = 13;
  localparam int ITEMS_PER_GEOMETRY = 150;
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic [2:0]        command;
    logic [CODE_W-1:0] char_code;
    logic [6:0]        pos_x;
    logic [5:0]        pos_y;
    logic [3:0]        text_color;
    logic [3:0]        back_color;
  } console_cmd_t;

  typedef struct packed {
    logic [CELL_AW-1:0] cursor_index;
    logic [CODE_W-1:0]  cell_char;
    logic [ATTR_W-1:0]  cell_attr;
    logic [ATTR_W-1:0]  current_attr;
  } console_result_t;

  typedef struct {
    console_cmd_t    cmd;
    bit              typed;
    console_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] command = '0;
  logic [CODE_W-1:0] char_code = '0;
  logic [6:0] pos_x = '0;
  logic [5:0] pos_y = '0;
  logic [3:0] text_color = '0;
  logic [3:0] back_color = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CELL_AW-1:0] cursor_index;
  logic [CODE_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;
  logic [ATTR_W-1:0] current_attr;
  logic cfg_write = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [COLS_W-1:0] cfg_data = '0;

  logic [CODE_W-1:0] shadow_codes [MAX_CELLS];
  logic [ATTR_W-1:0] shadow_attrs [MAX_CELLS];
  int unsigned shadow_cursor;
  logic [ATTR_W-1:0] shadow_colour;
  int unsigned screen_cols;
  int unsigned screen_rows;

  console_result_t console_outcomes [$];
  stim_row_t directed_rows [$];
  int unsigned errors = 0;
  int unsigned sink_left = 0;
  int unsigned idle_cycles = 0;
  bit calm = 1'b0;

  text_console_char_writer_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .char_code    (char_code),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .text_color   (text_color),
    .back_color   (back_color),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cursor_index (cursor_index),
    .cell_char    (cell_char),
    .cell_attr    (cell_attr),
    .current_attr (current_attr),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned active_cols();
    return (screen_cols == 0) ? 1 : screen_cols;
  endfunction

  function automatic int unsigned active_cells();
    int unsigned n;
    n = active_cols() * ((screen_rows == 0) ? 1 : screen_rows);
    return (n > MAX_CELLS) ? MAX_CELLS : n;
  endfunction

  function automatic console_result_t console_effect(input console_cmd_t c);
    console_result_t r;
    int unsigned total;
    int unsigned cols;
    int unsigned idx;
    total = active_cells();
    cols = active_cols();
    r = '0;
    shadow_cursor = shadow_cursor % MAX_CELLS;
    case (c.command)
      CMD_WRITE: begin
        if (c.char_code == CH_BS) begin
          shadow_cursor = (shadow_cursor == 0) ? total - 1 : (shadow_cursor - 1) % total;
        end else if (c.char_code == CH_CR) begin
          shadow_cursor = ((shadow_cursor / cols) * cols) % total;
        end else if (c.char_code == CH_LF) begin
          shadow_cursor = ((shadow_cursor / cols + 1) * cols) % total;
        end else begin
          shadow_codes[shadow_cursor] = c.char_code;
          shadow_attrs[shadow_cursor] = shadow_colour;
          shadow_cursor = (shadow_cursor + 1) % total;
        end
      end
      CMD_GOTO: begin
        shadow_cursor = (c.pos_x + c.pos_y * cols) % total;
      end
      CMD_CLEAR: begin
        for (int unsigned i = 0; i < total; i++) begin
          shadow_codes[i] = CH_SPACE;
          shadow_attrs[i] = shadow_colour;
        end
        shadow_cursor = 0;
      end
      CMD_COLOUR: begin
        shadow_colour = {c.back_color, c.text_color};
      end
      CMD_READ: begin
        idx = (c.pos_x + c.pos_y * cols) % total;
        r.cell_char = shadow_codes[idx];
        r.cell_attr = shadow_attrs[idx];
      end
      default: begin
      end
    endcase
    r.cursor_index = shadow_cursor[CELL_AW-1:0];
    r.current_attr = shadow_colour;
    return r;
  endfunction

  function automatic console_cmd_t random_cmd();
    console_cmd_t c;
    int unsigned pick;
    int unsigned sub;
    pick = $urandom_range(0, 99);
    sub = $urandom_range(0, 9);
    c.char_code = CODE_W'($urandom);
    c.pos_x = 7'($urandom_range(0, 127));
    c.pos_y = 6'($urandom_range(0, 63));
    c.text_color = 4'($urandom_range(0, 15));
    c.back_color = 4'($urandom_range(0, 15));
    if (pick < 50) begin
      c.command = CMD_WRITE;
      if (sub == 0) c.char_code = CH_BS;
      else if (sub == 1) c.char_code = CH_CR;
      else if (sub == 2) c.char_code = CH_LF;
      else if (sub < 6) c.char_code = CODE_W'($urandom_range(32, 126));
    end else if (pick < 62) begin
      c.command = CMD_GOTO;
    end else if (pick < 63) begin
      c.command = CMD_CLEAR;
    end else if (pick < 71) begin
      c.command = CMD_COLOUR;
    end else if (pick < 96) begin
      c.command = CMD_READ;
      if (sub < 6) begin
        c.pos_x = 7'($urandom_range(0, (active_cols() > 128) ? 127 : active_cols() - 1));
        c.pos_y = 6'($urandom_range(0, (active_cells() / active_cols() > 64) ? 63
                                       : active_cells() / active_cols() - 1));
      end
    end else begin
      c.command = (sub < 3) ? CMD_SPARE_5 : (sub < 6) ? CMD_SPARE_6 : CMD_SPARE_7;
    end
    return c;
  endfunction

  task automatic add_row(input logic [2:0] op, input logic [CODE_W-1:0] code,
                         input logic [6:0] x, input logic [5:0] y,
                         input logic [3:0] fg, input logic [3:0] bg,
                         input bit typed, input console_result_t want);
    stim_row_t row;
    row.cmd = {op, code, x, y, fg, bg};
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic send_item(input console_cmd_t item, input bit typed,
                           input console_result_t want);
    int unsigned gap;
    console_result_t predicted;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= item.command;
    char_code <= item.char_code;
    pos_x <= item.pos_x;
    pos_y <= item.pos_y;
    text_color <= item.text_color;
    back_color <= item.back_color;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predicted = console_effect(item);
    console_outcomes.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    while (console_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [COLS_W-1:0] cols, input logic [ROWS_W-1:0] rows);
    cfg_write <= 1'b1;
    cfg_index <= REG_COLUMNS;
    cfg_data <= cols;
    @(posedge clk);
    cfg_index <= REG_ROWS;
    cfg_data <= {1'b0, rows};
    @(posedge clk);
    cfg_write <= 1'b0;
    screen_cols = 32'(cols);
    screen_rows = 32'(rows);
  endtask

  always @(posedge clk) begin : result_sink
    int unsigned hold;
    console_result_t seen;
    if (rst) begin
      out_stall <= 1'b0;
      sink_left <= 0;
    end else if (out_valid && !out_stall) begin
      seen = {cursor_index, cell_char, cell_attr, current_attr};
      if (console_outcomes.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer cursor %0d char %h attr %h colour %h", $time,
                 seen.cursor_index, seen.cell_char, seen.cell_attr, seen.current_attr);
      end else if (seen !== console_outcomes[0]) begin
        errors++;
        $display("%0t: mismatch expected cursor %0d char %h attr %h colour %h", $time,
                 console_outcomes[0].cursor_index, console_outcomes[0].cell_char,
                 console_outcomes[0].cell_attr, console_outcomes[0].current_attr);
        $display("%0t:          actual   cursor %0d char %h attr %h colour %h", $time,
                 seen.cursor_index, seen.cell_char, seen.cell_attr, seen.current_attr);
      end
      if (console_outcomes.size() != 0) void'(console_outcomes.pop_front());
      hold = calm ? 0 : $urandom_range(0, 3);
      sink_left <= hold;
      out_stall <= (hold != 0);
    end else if (sink_left > 1) begin
      sink_left <= sink_left - 1;
    end else if (sink_left == 1) begin
      sink_left <= 0;
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned geo_cols [GEOMETRIES];
    int unsigned geo_rows [GEOMETRIES];
    for (int i = 0; i < MAX_CELLS; i++) begin
      shadow_codes[i] = CH_NULL;
      shadow_attrs[i] = ATTR_RESET;
    end
    shadow_cursor = 0;
    shadow_colour = ATTR_RESET;
    screen_cols = COLUMNS_RESET;
    screen_rows = ROWS_RESET;

    // reset geometry is 80 x 25, so the far corner folds onto cell 1167
    add_row(CMD_READ,    16'h0000, 7'd0,   6'd0,  4'h0, 4'h0, 1, {13'd0,    16'h0000, 8'h07, 8'h07});
    add_row(CMD_READ,    16'h0000, 7'd127, 6'd63, 4'h0, 4'h0, 1, {13'd0,    16'h0000, 8'h07, 8'h07});
    add_row(CMD_WRITE,   CH_BS,    7'd0,   6'd0,  4'h0, 4'h0, 1, {13'd1999, 16'h0000, 8'h00, 8'h07});
    add_row(CMD_WRITE,   16'hFFFF, 7'd0,   6'd0,  4'h0, 4'h0, 1, {13'd0,    16'h0000, 8'h00, 8'h07});
    add_row(CMD_COLOUR,  16'h0000, 7'd0,   6'd0,  4'hF, 4'hF, 1, {13'd0,    16'h0000, 8'h00, 8'hFF});
    add_row(CMD_SPARE_5, 16'hFFFF, 7'd127, 6'd63, 4'hF, 4'hF, 1, {13'd0,    16'h0000, 8'h00, 8'hFF});
    add_row(CMD_SPARE_6, 16'h0000, 7'd0,   6'd0,  4'h0, 4'h0, 1, {13'd0,    16'h0000, 8'h00, 8'hFF});
    add_row(CMD_SPARE_7, 16'h1234, 7'd5,   6'd5,  4'h3, 4'hC, 1, {13'd0,    16'h0000, 8'h00, 8'hFF});
    add_row(CMD_WRITE,   16'h0000, 7'd0,   6'd0,  4'h0, 4'h0, 0, '0);
    add_row(CMD_READ,    16'h0000, 7'd79,  6'd24, 4'h0, 4'h0, 1, {13'd1,    16'hFFFF, 8'h07, 8'hFF});
    add_row(CMD_READ,    16'h0000, 7'd0,   6'd0,  4'h0, 4'h0, 0, '0);
    add_row(CMD_GOTO,    16'h0000, 7'd127, 6'd63, 4'h0, 4'h0, 1, {13'd1167, 16'h0000, 8'h00, 8'hFF});
    add_row(CMD_WRITE,   CH_CR,    7'd0,   6'd0,  4'h0, 4'h0, 0, '0);
    add_row(CMD_WRITE,   CH_LF,    7'd0,   6'd0,  4'h0, 4'h0, 0, '0);
    add_row(CMD_GOTO,    16'h0000, 7'd0,   6'd24, 4'h0, 4'h0, 0, '0);
    add_row(CMD_WRITE,   CH_CR,    7'd0,   6'd0,  4'h0, 4'h0, 0, '0);
    add_row(CMD_WRITE,   CH_LF,    7'd0,   6'd0,  4'h0, 4'h0, 0, '0);
    add_row(CMD_COLOUR,  16'h0000, 7'd0,   6'd0,  4'h0, 4'h0, 0, '0);
    add_row(CMD_WRITE,   16'hAAAA, 7'd0,   6'd0,  4'h0, 4'h0, 0, '0);
    add_row(CMD_WRITE,   16'h5555, 7'd0,   6'd0,  4'h0, 4'h0, 0, '0);
    add_row(CMD_WRITE,   CH_BS,    7'd0,   6'd0,  4'h0, 4'h0, 0, '0);
    add_row(CMD_CLEAR,   16'h0000, 7'd0,   6'd0,  4'h0, 4'h0, 0, '0);
    add_row(CMD_READ,    16'h0000, 7'd0,   6'd0,  4'h0, 4'h0, 0, '0);
    add_row(CMD_READ,    16'h0000, 7'd79,  6'd24, 4'h0, 4'h0, 0, '0);
    add_row(CMD_COLOUR,  16'h0000, 7'd0,   6'd0,  4'hA, 4'h5, 0, '0);

    geo_cols[0] = 80;  geo_rows[0] = 25;
    geo_cols[1] = 1;   geo_rows[1] = 1;
    geo_cols[2] = 128; geo_rows[2] = 64;
    geo_cols[3] = 1;   geo_rows[3] = 64;
    geo_cols[4] = 128; geo_rows[4] = 1;
    for (int g = 5; g < GEOMETRIES; g++) begin
      if ($urandom_range(0, 3) != 0) begin
        geo_cols[g] = $urandom_range(1, 16);
        geo_rows[g] = $urandom_range(1, 8);
      end else begin
        geo_cols[g] = $urandom_range(1, 128);
        geo_rows[g] = $urandom_range(1, 64);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
    end
    in_valid <= 1'b0;

    for (int g = 0; g < GEOMETRIES; g++) begin
      drain();
      set_geometry(COLS_W'(geo_cols[g]), ROWS_W'(geo_rows[g]));
      calm = (g % 4 == 3);
      repeat (ITEMS_PER_GEOMETRY) send_item(random_cmd(), 0, '0);
      in_valid <= 1'b0;
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
